// ===== rtl/gmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_pkg: shared types and constants of the grid max pooling downsampler
// Holds the map limits, the register indexes and the work item that the
// front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package gmp_pkg;

    localparam int MAX_MAP_WIDTH  = 1024;
    localparam int MAX_MAP_HEIGHT = 1024;
    localparam int MAX_FACTOR     = 16;

    localparam int CFG_W    = 11;
    localparam int FACTOR_W = 5;
    localparam int COORD_W  = 10;
    localparam int INBLK_W  = 4;
    localparam int COST_W   = 7;
    localparam int IN_W     = 8;
    localparam int ADDR_W   = $clog2(MAX_MAP_WIDTH);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FACTOR = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COORD_W-1:0] out_y;
        logic [COST_W-1:0]  cost;
        logic               first;
        logic               emit;
        logic               done;
    } t_item;

endpackage

// ===== rtl/gmp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_front: input classifier
// Holds the configuration registers and the position counters, and turns
// each accepted cell into a work item with its band address and block flags.
// ----------------------------------------------------------------------------
module gmp_front import gmp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic [IN_W-1:0]      i_cell_cost,
    output t_item                o_item
);

    logic [CFG_W-1:0]    r_map_width;
    logic [CFG_W-1:0]    r_map_height;
    logic [FACTOR_W-1:0] r_block_factor;
    logic [COORD_W-1:0]  r_col;
    logic [COORD_W-1:0]  r_row;
    logic [INBLK_W-1:0]  r_ibc;
    logic [INBLK_W-1:0]  r_ibr;
    logic [COORD_W-1:0]  r_out_col;
    logic [COORD_W-1:0]  r_out_row;

    logic [CFG_W-1:0]    w_eff;
    logic [CFG_W-1:0]    h_eff;
    logic [FACTOR_W-1:0] f_eff;
    logic                last_col;
    logic                last_row;
    logic                blk_col_end;
    logic                blk_row_end;

    always_comb begin
        if (r_map_width == '0) begin
            w_eff = CFG_W'(1);
        end else if (r_map_width > CFG_W'(MAX_MAP_WIDTH)) begin
            w_eff = CFG_W'(MAX_MAP_WIDTH);
        end else begin
            w_eff = r_map_width;
        end
        if (r_map_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (r_map_height > CFG_W'(MAX_MAP_HEIGHT)) begin
            h_eff = CFG_W'(MAX_MAP_HEIGHT);
        end else begin
            h_eff = r_map_height;
        end
        if (r_block_factor == '0) begin
            f_eff = FACTOR_W'(1);
        end else if (r_block_factor > FACTOR_W'(MAX_FACTOR)) begin
            f_eff = FACTOR_W'(MAX_FACTOR);
        end else begin
            f_eff = r_block_factor;
        end
    end

    assign last_col    = ({1'b0, r_col} + CFG_W'(1)) >= w_eff;
    assign last_row    = ({1'b0, r_row} + CFG_W'(1)) >= h_eff;
    assign blk_col_end = (({1'b0, r_ibc} + FACTOR_W'(1)) >= f_eff) || last_col;
    assign blk_row_end = (({1'b0, r_ibr} + FACTOR_W'(1)) >= f_eff) || last_row;

    always_comb begin
        o_item.addr  = r_out_col;
        o_item.out_y = r_out_row;
        o_item.cost  = i_cell_cost[IN_W-1] ? '0 : i_cell_cost[COST_W-1:0];
        o_item.first = (r_ibc == '0) && (r_ibr == '0);
        o_item.emit  = blk_col_end && blk_row_end;
        o_item.done  = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width    <= CFG_W'(MAX_MAP_WIDTH);
            r_map_height   <= CFG_W'(MAX_MAP_HEIGHT);
            r_block_factor <= FACTOR_W'(2);
            r_col          <= '0;
            r_row          <= '0;
            r_ibc          <= '0;
            r_ibr          <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else if (i_cfg_wr_en && (i_cfg_addr == CFG_MAP_WIDTH ||
                     i_cfg_addr == CFG_MAP_HEIGHT || i_cfg_addr == CFG_BLOCK_FACTOR)) begin
            if (i_cfg_addr == CFG_MAP_WIDTH) begin
                r_map_width <= i_cfg_data;
            end
            if (i_cfg_addr == CFG_MAP_HEIGHT) begin
                r_map_height <= i_cfg_data;
            end
            if (i_cfg_addr == CFG_BLOCK_FACTOR) begin
                r_block_factor <= i_cfg_data[FACTOR_W-1:0];
            end
            r_col     <= '0;
            r_row     <= '0;
            r_ibc     <= '0;
            r_ibr     <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_accept) begin
            if (last_col) begin
                r_col     <= '0;
                r_ibc     <= '0;
                r_out_col <= '0;
                if (last_row) begin
                    r_row     <= '0;
                    r_ibr     <= '0;
                    r_out_row <= '0;
                end else begin
                    r_row <= r_row + COORD_W'(1);
                    if (blk_row_end) begin
                        r_ibr     <= '0;
                        r_out_row <= r_out_row + COORD_W'(1);
                    end else begin
                        r_ibr <= r_ibr + INBLK_W'(1);
                    end
                end
            end else begin
                r_col <= r_col + COORD_W'(1);
                if (blk_col_end) begin
                    r_ibc     <= '0;
                    r_out_col <= r_out_col + COORD_W'(1);
                end else begin
                    r_ibc <= r_ibc + INBLK_W'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/gmp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_queue: work item queue
// A short first-in first-out buffer in flip-flops between front and back end.
// ----------------------------------------------------------------------------
module gmp_queue import gmp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("push into full queue");

endmodule

// ===== rtl/gmp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_back: band store update and result output
// Reads the running maximum of the item's output column from the band store,
// merges the cell cost, writes it back and registers a result on block end.
// ----------------------------------------------------------------------------
module gmp_back import gmp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_item                  i_q_item,
    output logic                   o_q_pop,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    logic [COST_W-1:0]  r_band [MAX_MAP_WIDTH];
    logic [COST_W-1:0]  r_rd;
    logic               r_fwd;
    logic [COST_W-1:0]  r_fwd_val;
    t_item              r_b2;
    logic               r_b2_valid;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [COST_W-1:0]  r_out_cost;
    logic               r_out_done;

    logic [COST_W-1:0]  prev;
    logic [COST_W-1:0]  merged;
    logic               out_free;
    logic               b2_leave;
    logic               load;

    assign prev     = r_fwd ? r_fwd_val : r_rd;
    assign merged   = (r_b2.first || r_b2.cost > prev) ? r_b2.cost : prev;
    assign out_free = !r_out_valid || i_m_tready;
    assign b2_leave = r_b2_valid && (!r_b2.emit || out_free);
    assign load     = i_q_valid && (!r_b2_valid || b2_leave);
    assign o_q_pop  = load;

    always_ff @(posedge i_clk) begin
        if (b2_leave) begin
            r_band[r_b2.addr] <= merged;
        end
        if (load) begin
            r_rd <= r_band[i_q_item.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b2      <= i_q_item;
            r_fwd_val <= merged;
        end
        if (b2_leave && r_b2.emit) begin
            r_out_x    <= r_b2.addr;
            r_out_y    <= r_b2.out_y;
            r_out_cost <= merged;
            r_out_done <= r_b2.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_b2_valid <= 1'b1;
                r_fwd      <= r_b2_valid && (r_b2.addr == i_q_item.addr);
            end else if (b2_leave) begin
                r_b2_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
            if (b2_leave && r_b2.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - 2*COORD_W - COST_W){1'b0}},
                         r_out_cost, r_out_y, r_out_x};
    assign o_m_tlast  = r_out_done;

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_b2_valid)
        else $error("forwarding flag without an item in the update stage");
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b2_leave && r_b2.emit) |-> out_free)
        else $error("result overwrites an untaken result");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output beat changed while waiting");

endmodule

// ===== rtl/grid_max_pool_downsampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_max_pool_downsampler: streaming 2D max pooling of a cost grid
// Channel    Dir  Beat content
// s (in)     in   tdata[7:0] cell_cost, signed
// m (out)    out  tdata[9:0] out_x, [19:10] out_y, [26:20] out_cost; tlast map_done
// cfg        in   wr_en, addr (0 width, 1 height, 2 factor), data[10:0]
//
// One cell beat is taken every cycle unless the queue is full; the band store
// does one read and one write per cycle, with the result of the previous beat
// forwarded. A block-ending cell goes through the queue and the update stage
// to the output register. A stalled output fills the four-entry queue, then
// drops s_tready. Reset is synchronous; the band store needs no clearing pass.
// ----------------------------------------------------------------------------
module grid_max_pool_downsampler import gmp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] cell_cost
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [9:0] out_x, [19:10] out_y, [26:20] out_cost
    output logic                   o_m_tlast
);

    t_item front_item;
    t_item head_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  accept;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    gmp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_cell_cost (i_s_tdata[IN_W-1:0]),
        .o_item      (front_item)
    );

    gmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    gmp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (head_item),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
